@@ sv/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, constants and byte-level round functions for the AES core.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int RKW_DEFAULT = 60;   // round-key words kept in the store
  localparam int NUM_RK      = 15;   // round keys 0..14
  localparam int CNT_W       = 6;    // key expansion word counter
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3  = 3'd4;

  localparam logic [1:0] KLEN_128 = 2'd0;
  localparam logic [1:0] KLEN_192 = 2'd1;

  typedef enum logic {KX_IDLE, KX_RUN} kx_state_t;

  typedef struct packed {
    logic         op;
    logic [127:0] blk;
  } aes_word_t;

  typedef struct packed {
    logic first;
    logic active;
    logic last;
  } aes_ctl_t;

  typedef logic [7:0] sbox_tab_t [0:255];

  localparam sbox_tab_t SBOX = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic sbox_tab_t make_inv_sbox();
    sbox_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[SBOX[i]] = 8'(i);
    end
    return t;
  endfunction

  localparam sbox_tab_t INV_SBOX = make_inv_sbox();

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [3:0] nr_of(input logic [1:0] klen);
    logic [3:0] n;
    case (klen)
      KLEN_128: n = 4'd10;
      KLEN_192: n = 4'd12;
      default:  n = 4'd14;   // code three runs as 256 bit
    endcase
    return n;
  endfunction

  // byte i of the block sits at [127-8i -: 8]
  function automatic logic [127:0] byte_sub(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) begin
      t[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
    end
    return t;
  endfunction

  function automatic logic [31:0] word_sub(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [127:0] row_shift(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (inv) begin
          t[127-8*(r+4*((c+r)&3)) -: 8] = s[127-8*(r+4*c) -: 8];
        end else begin
          t[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)&3)) -: 8];
        end
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] col_mix(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0] a [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [7:0] x2, x4, x8;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]  = s[127-8*(4*c+k) -: 8];
        x2    = xt(a[k]);
        x4    = xt(x2);
        x8    = xt(x4);
        m2[k] = x2;
        m3[k] = x2 ^ a[k];
        m9[k] = x8 ^ a[k];
        mb[k] = x8 ^ x2 ^ a[k];
        md[k] = x8 ^ x4 ^ a[k];
        me[k] = x8 ^ x4 ^ x2;
      end
      if (inv) begin
        t[127-8*(4*c+0) -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
        t[127-8*(4*c+1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
        t[127-8*(4*c+2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
        t[127-8*(4*c+3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
      end else begin
        t[127-8*(4*c+0) -: 8] = m2[0] ^ m3[1] ^ a[2] ^ a[3];
        t[127-8*(4*c+1) -: 8] = a[0] ^ m2[1] ^ m3[2] ^ a[3];
        t[127-8*(4*c+2) -: 8] = a[0] ^ a[1] ^ m2[2] ^ m3[3];
        t[127-8*(4*c+3) -: 8] = m3[0] ^ a[1] ^ a[2] ^ m2[3];
      end
    end
    return t;
  endfunction

endpackage

@@ sv/aes_if.sv @@
// ----------------------------------------------------------------------------
// aes_in_if / aes_out_if
// Valid/ready channels for plaintext or ciphertext blocks in and results out.
// ----------------------------------------------------------------------------
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] block_hi;
  logic [63:0] block_lo;

  modport source (output valid, op, block_hi, block_lo, input ready);
  modport sink   (input valid, op, block_hi, block_lo, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_hi;
  logic [63:0] result_lo;

  modport source (output valid, result_hi, result_lo, input ready);
  modport sink   (input valid, result_hi, result_lo, output ready);
endinterface

@@ sv/aes_key_expand.sv @@
// ----------------------------------------------------------------------------
// aes_key_expand
// Expands the key registers into the round-key store, one word per cycle.
// ----------------------------------------------------------------------------
module aes_key_expand
  import aes_pkg::*;
#(
  parameter int ROUND_KEY_WORDS = RKW_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [1:0]                key_length,
  input  logic [3:0][63:0]          key_words,
  output logic                      busy,
  output logic [NUM_RK-1:0][127:0]  round_keys
);

  localparam int KIDX_W = $clog2(ROUND_KEY_WORDS);

  kx_state_t        state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [2:0]       mod_r, mod_nxt;
  logic [7:0]       rcon_r, rcon_nxt;
  logic [31:0]      win_r [8];
  logic [31:0]      store_r [ROUND_KEY_WORDS];

  logic [3:0]       nk;
  logic [CNT_W-1:0] last_idx;
  logic [31:0]      w_prev, w_back, t, key_half, new_word;
  logic [63:0]      kw;

  always_comb begin
    case (key_length)
      KLEN_128: begin
        nk       = 4'd4;
        last_idx = CNT_W'(43);
        w_back   = win_r[3];
      end
      KLEN_192: begin
        nk       = 4'd6;
        last_idx = CNT_W'(51);
        w_back   = win_r[5];
      end
      default: begin
        nk       = 4'd8;
        last_idx = CNT_W'(59);
        w_back   = win_r[7];
      end
    endcase
  end

  assign w_prev   = win_r[0];
  assign kw       = key_words[idx_r[2:1]];
  assign key_half = idx_r[0] ? kw[31:0] : kw[63:32];

  always_comb begin
    if (mod_r == 3'd0) begin
      t = word_sub({w_prev[23:0], w_prev[31:24]}) ^ {rcon_r, 24'h0};
    end else if (nk == 4'd8 && mod_r == 3'd4) begin
      t = word_sub(w_prev);
    end else begin
      t = w_prev;
    end
    new_word = ({2'b00, idx_r} < {4'h0, nk}) ? key_half : (w_back ^ t);
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    mod_nxt   = mod_r;
    rcon_nxt  = rcon_r;
    case (state_r)
      KX_IDLE: ;
      KX_RUN: begin
        idx_nxt = idx_r + CNT_W'(1);
        mod_nxt = (mod_r == 3'(nk - 4'd1)) ? 3'd0 : mod_r + 3'd1;
        if (mod_r == 3'd0 && {2'b00, idx_r} >= {4'h0, nk}) begin
          rcon_nxt = xt(rcon_r);
        end
        if (idx_r == last_idx) begin
          state_nxt = KX_IDLE;
        end
      end
      default: state_nxt = KX_IDLE;
    endcase
    // a key write restarts the expansion
    if (start) begin
      state_nxt = KX_RUN;
      idx_nxt   = '0;
      mod_nxt   = '0;
      rcon_nxt  = 8'h01;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= KX_RUN;
      idx_r   <= '0;
      mod_r   <= '0;
      rcon_r  <= 8'h01;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      mod_r   <= mod_nxt;
      rcon_r  <= rcon_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == KX_RUN) begin
      win_r[0] <= new_word;
      for (int k = 1; k < 8; k++) begin
        win_r[k] <= win_r[k-1];
      end
      if (idx_r < CNT_W'(ROUND_KEY_WORDS)) begin
        store_r[idx_r[KIDX_W-1:0]] <= new_word;
      end
    end
  end

  assign busy = (state_r == KX_RUN);

  // words past the end of the store read as zero
  for (genvar r = 0; r < NUM_RK; r++) begin : g_rk
    for (genvar c = 0; c < 4; c++) begin : g_col
      if (4*r + c < ROUND_KEY_WORDS) begin : g_kept
        assign round_keys[r][127-32*c -: 32] = store_r[4*r+c];
      end else begin : g_zero
        assign round_keys[r][127-32*c -: 32] = '0;
      end
    end
  end

endmodule

@@ sv/aes_round.sv @@
// ----------------------------------------------------------------------------
// aes_round
// One pipeline stage: a cipher or inverse-cipher round, the initial key add or a pass-through, with its register.
// ----------------------------------------------------------------------------
module aes_round
  import aes_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         valid_i,
  output logic         ready_o,
  input  aes_word_t    din,
  input  aes_ctl_t     ctl,
  input  logic [127:0] round_key,
  output logic         valid_o,
  input  logic         ready_i,
  output aes_word_t    dout
);

  logic         valid_r;
  aes_word_t    data_r;
  logic [127:0] e1, e2, e3, d1, d2, d3, enc, dec, res;

  always_comb begin
    e1  = byte_sub(din.blk, 1'b0);
    e2  = row_shift(e1, 1'b0);
    e3  = ctl.last ? e2 : col_mix(e2, 1'b0);
    enc = e3 ^ round_key;
    d1  = row_shift(din.blk, 1'b1);
    d2  = byte_sub(d1, 1'b1);
    d3  = d2 ^ round_key;
    dec = ctl.last ? d3 : col_mix(d3, 1'b1);
    if (ctl.first) begin
      res = din.blk ^ round_key;
    end else if (!ctl.active) begin
      res = din.blk;   // rounds past the key's round count pass through
    end else begin
      res = din.op ? dec : enc;
    end
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r.op  <= din.op;
      data_r.blk <= res;
    end
  end

  assign valid_o = valid_r;
  assign dout    = data_r;

endmodule

@@ sv/aes_block_encrypt_decrypt_top.sv @@
// ----------------------------------------------------------------------------
// aes_block_encrypt_decrypt_top
// AES-128/192/256 ECB block cipher, encrypt or decrypt per word.
// ----------------------------------------------------------------------------
// Fifteen register stages (initial key add and fourteen rounds) take one word
// per cycle in either direction unless out_ch stalls or the key schedule is
// being rebuilt; every word passes all stages, with shorter keys passing
// through the spare rounds. After reset and after every configuration write
// the key schedule is rebuilt one 32-bit word per cycle (44, 52 or 60 words
// for 128, 192 or 256 bit keys); in_ch.ready stays low until it is done.
module aes_block_encrypt_decrypt_top
  import aes_pkg::*;
#(
  parameter int ROUND_KEY_WORDS = RKW_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  aes_in_if.sink               in_ch,
  aes_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  logic [1:0]               key_length_r;
  logic [3:0][63:0]         key_word_r;
  logic                     kx_start, kx_busy;
  logic [NUM_RK-1:0][127:0] round_keys;
  logic [3:0]               nr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= '0;
      key_word_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_LENGTH: key_length_r  <= cfg_data[1:0];
        CFG_KEY_WORD0:  key_word_r[0] <= cfg_data;
        CFG_KEY_WORD1:  key_word_r[1] <= cfg_data;
        CFG_KEY_WORD2:  key_word_r[2] <= cfg_data;
        CFG_KEY_WORD3:  key_word_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign kx_start = cfg_we;
  assign nr       = nr_of(key_length_r);

  aes_key_expand #(
    .ROUND_KEY_WORDS(ROUND_KEY_WORDS)
  ) u_kx (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (kx_start),
    .key_length (key_length_r),
    .key_words  (key_word_r),
    .busy       (kx_busy),
    .round_keys (round_keys)
  );

  logic      valid [NUM_RK+1];
  logic      rdy   [NUM_RK+1];
  aes_word_t data  [NUM_RK+1];

  assign valid[0]        = in_ch.valid && !kx_busy;
  assign in_ch.ready     = rdy[0] && !kx_busy;
  assign data[0].op      = in_ch.op;
  assign data[0].blk     = {in_ch.block_hi, in_ch.block_lo};
  assign rdy[NUM_RK]     = out_ch.ready;
  assign out_ch.valid    = valid[NUM_RK];
  assign out_ch.result_hi = data[NUM_RK].blk[127:64];
  assign out_ch.result_lo = data[NUM_RK].blk[63:0];

  for (genvar j = 0; j < NUM_RK; j++) begin : g_stage
    // decrypt walks the schedule backwards from round nr
    localparam int I10 = (j <= 10) ? 10 - j : 0;
    localparam int I12 = (j <= 12) ? 12 - j : 0;
    localparam int I14 = 14 - j;

    aes_ctl_t     ctl;
    logic [127:0] dec_key, rk;

    always_comb begin
      case (key_length_r)
        KLEN_128: dec_key = round_keys[I10];
        KLEN_192: dec_key = round_keys[I12];
        default:  dec_key = round_keys[I14];
      endcase
      rk         = data[j].op ? dec_key : round_keys[j];
      ctl.first  = (j == 0);
      ctl.active = (4'(j) <= nr);
      ctl.last   = (4'(j) == nr);
    end

    aes_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_i   (valid[j]),
      .ready_o   (rdy[j]),
      .din       (data[j]),
      .ctl       (ctl),
      .round_key (rk),
      .valid_o   (valid[j+1]),
      .ready_i   (rdy[j+1]),
      .dout      (data[j+1])
    );
  end

endmodule

@@ sv/aes_chk.sv @@
// ----------------------------------------------------------------------------
// aes_chk
// Port-level checks on the AES core: key schedule gating and output flow.
// ----------------------------------------------------------------------------
module aes_chk (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_we
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped under stall");

  // key schedule rebuild blocks input right after any configuration write
  a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input taken during key schedule rebuild");

  // the schedule is rebuilt after reset before any word is taken
  a_rst_block: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken right after reset");

  // the pipeline is empty coming out of reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word right after reset");

endmodule

bind aes_block_encrypt_decrypt_top aes_chk u_aes_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .cfg_we    (cfg_we)
);

@@ tb/aes_block_encrypt_decrypt_top_tb.sv @@
// ----------------------------------------------------------------------------
// aes_block_encrypt_decrypt_top_tb
// Drives random and directed blocks through the AES core under 128, 192, 256
// bit keys and key length code three, and checks every result against an
// in-bench cipher model built from GF(2^8) arithmetic.
// ----------------------------------------------------------------------------
module aes_block_encrypt_decrypt_top_tb;
  import aes_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM       = 1400;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_blk_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_data;

  aes_in_if  in_ch();
  aes_out_if out_ch();

  int errors;
  int idle_cycles;
  int n_blocks;
  int n_enc;
  int n_dec;

  // testbench copy of the key registers and schedule
  logic [1:0]  key_len_m;
  logic [63:0] key_regs_m [4];
  logic [31:0] sched_m [60];

  aes_block_encrypt_decrypt_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  class cipher_scoreboard;
    cipher_blk_t pending[$];

    function void note_block(cipher_blk_t want);
      pending.push_back(want);
    endfunction

    task check_result(logic [63:0] hi, logic [63:0] lo);
      cipher_blk_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word", hi, lo);
        return;
      end
      want = pending.pop_front();
      if (hi !== want.hi) report_mismatch("result_hi", hi, want.hi);
      if (lo !== want.lo) report_mismatch("result_lo", lo, want.lo);
    endtask
  endclass

  cipher_scoreboard sb;

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [8:0] x;
    logic [7:0] p;
    x = {1'b0, a};
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= x[7:0];
      x = x << 1;
      if (x[8]) x ^= 9'h11b;
    end
    return p;
  endfunction

  function automatic logic [7:0] ginv(logic [7:0] a);
    logic [7:0] r, b;
    r = 8'h01;
    b = a;
    for (int e = 0; e < 8; e++) begin
      if (e != 0) r = gmul(r, b);
      b = gmul(b, b);
    end
    return r;
  endfunction

  function automatic logic [7:0] rol8(logic [7:0] v, int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [7:0] sb_fwd(logic [7:0] x);
    logic [7:0] b;
    b = ginv(x);
    return b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] sb_inv(logic [7:0] y);
    logic [7:0] x;
    x = y ^ 8'h63;
    return ginv(rol8(x, 1) ^ rol8(x, 3) ^ rol8(x, 6));
  endfunction

  function automatic int key_nk_m();
    return key_len_m == 2'd0 ? 4 : (key_len_m == 2'd1 ? 6 : 8);
  endfunction

  function automatic logic [31:0] subw_m(logic [31:0] w);
    return {sb_fwd(w[31:24]), sb_fwd(w[23:16]), sb_fwd(w[15:8]), sb_fwd(w[7:0])};
  endfunction

  function automatic void rebuild_schedule();
    int nk, total;
    logic [7:0] rc;
    logic [31:0] t;
    nk = key_nk_m();
    total = 4 * (nk + 7);
    rc = 8'h01;
    for (int i = 0; i < 60; i++) sched_m[i] = '0;
    for (int i = 0; i < nk; i++)
      sched_m[i] = i[0] ? key_regs_m[i >> 1][31:0] : key_regs_m[i >> 1][63:32];
    for (int i = nk; i < total; i++) begin
      t = sched_m[i-1];
      if (i % nk == 0) begin
        t = subw_m({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gmul(rc, 8'h02);
      end else if (nk > 6 && i % nk == 4) begin
        t = subw_m(t);
      end
      sched_m[i] = sched_m[i-nk] ^ t;
    end
  endfunction

  function automatic cipher_blk_t transform_block(logic dec, logic [63:0] hi,
                                                  logic [63:0] lo);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, m0, m1, m2, m3;
    int nr, rk;
    cipher_blk_t res;
    nr = key_nk_m() + 6;
    for (int i = 0; i < 8; i++) begin
      s[i]   = hi[63-8*i -: 8];
      s[i+8] = lo[63-8*i -: 8];
    end
    m0 = dec ? 8'd14 : 8'd2;
    m1 = dec ? 8'd11 : 8'd3;
    m2 = dec ? 8'd13 : 8'd1;
    m3 = dec ? 8'd9 : 8'd1;
    // step 0 is the first key add; steps 1..nr are rounds
    for (int st = 0; st <= nr; st++) begin
      rk = dec ? nr - st : st;
      if (st != 0) begin
        if (!dec) for (int i = 0; i < 16; i++) s[i] = sb_fwd(s[i]);
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++)
            if (dec) t[r + 4*((c + r) & 3)] = s[r + 4*c];
            else     t[r + 4*c] = s[r + 4*((c + r) & 3)];
        s = t;
        if (dec) for (int i = 0; i < 16; i++) s[i] = sb_inv(s[i]);
        if (!dec && st != nr) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
            s[4*c]   = gmul(a0,m0) ^ gmul(a1,m1) ^ gmul(a2,m2) ^ gmul(a3,m3);
            s[4*c+1] = gmul(a0,m3) ^ gmul(a1,m0) ^ gmul(a2,m1) ^ gmul(a3,m2);
            s[4*c+2] = gmul(a0,m2) ^ gmul(a1,m3) ^ gmul(a2,m0) ^ gmul(a3,m1);
            s[4*c+3] = gmul(a0,m1) ^ gmul(a1,m2) ^ gmul(a2,m3) ^ gmul(a3,m0);
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int k = 0; k < 4; k++)
          s[4*c+k] ^= sched_m[4*rk + c][31-8*k -: 8];
      if (dec && st != 0 && st != nr) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          s[4*c]   = gmul(a0,m0) ^ gmul(a1,m1) ^ gmul(a2,m2) ^ gmul(a3,m3);
          s[4*c+1] = gmul(a0,m3) ^ gmul(a1,m0) ^ gmul(a2,m1) ^ gmul(a3,m2);
          s[4*c+2] = gmul(a0,m2) ^ gmul(a1,m3) ^ gmul(a2,m0) ^ gmul(a3,m1);
          s[4*c+3] = gmul(a0,m1) ^ gmul(a1,m2) ^ gmul(a2,m3) ^ gmul(a3,m0);
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63-8*i -: 8] = s[i];
      res.lo[63-8*i -: 8] = s[i+8];
    end
    return res;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic idle_cycles_wait(input int n);
    repeat (n) @(posedge clk);
  endtask

  // valid stays high after an accept until a gap or a drain drops it
  task automatic send_block(input logic dec, input logic [63:0] hi,
                            input logic [63:0] lo, input bit no_gap);
    int n;
    n = no_gap ? 0 : gap_len();
    if (n != 0) begin
      in_ch.valid <= 1'b0;
      idle_cycles_wait(n);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= dec;
    in_ch.block_hi <= hi;
    in_ch.block_lo <= lo;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_block(transform_block(dec, hi, lo));
    n_blocks++;
    if (dec) n_dec++; else n_enc++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    idle_cycles_wait(20);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_KEY_LENGTH) key_len_m = val[1:0];
    else if (idx <= CFG_KEY_WORD3) key_regs_m[idx - 1] = val;
    rebuild_schedule();
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic run_blocks(input int n);
    logic [63:0] hi, lo;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      hi = rnd64();
      lo = rnd64();
      if (k == 0) hi = '1;
      if (k == 1) lo = '0;
      send_block(1'($urandom_range(0, 1)), hi, lo, ($urandom_range(0, 4) == 0));
    end
  endtask

  // result side: random stalls, accepted words checked in order
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.result_hi, out_ch.result_lo);
      out_ch.ready <= (gap_len() == 0) || ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("aes_block_encrypt_decrypt_top_tb failed");
      $finish;
    end
  end

  initial begin
    logic [1:0] klens [5];
    sb = new();
    errors = 0; idle_cycles = 0; n_blocks = 0; n_enc = 0; n_dec = 0;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_ch.valid = 1'b0; in_ch.op = 1'b0; in_ch.block_hi = '0; in_ch.block_lo = '0;
    out_ch.ready = 1'b0;
    key_len_m = '0;
    for (int i = 0; i < 4; i++) key_regs_m[i] = '0;
    rebuild_schedule();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: all-zero key after reset, extremes of the block, both directions
    send_block(1'b0, '0, '0, 1'b1);
    send_block(1'b1, '0, '0, 1'b1);
    send_block(1'b0, '1, '1, 1'b1);
    send_block(1'b1, '1, '1, 1'b1);
    drain();
    // standard test key and block
    write_reg(CFG_KEY_WORD0, 64'h0001020304050607);
    write_reg(CFG_KEY_WORD1, 64'h08090a0b0c0d0e0f);
    write_reg(CFG_KEY_WORD2, 64'h1011121314151617);
    write_reg(CFG_KEY_WORD3, 64'h18191a1b1c1d1e1f);
    for (int l = 0; l < 4; l++) begin
      write_reg(CFG_KEY_LENGTH, 64'(l));
      send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
      send_block(1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
      send_block(1'b0, 64'h8000000000000000, 64'h0000000000000001, 1'b1);
      drain();
    end
    // out-of-range register index must be ignored
    write_reg(3'd5, rnd64());
    write_reg(3'd7, rnd64());
    send_block(1'b0, rnd64(), rnd64(), 1'b0);
    drain();

    // random phases across key sizes, extreme keys included
    klens = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2};
    for (int p = 0; p < 7; p++) begin
      write_reg(CFG_KEY_LENGTH, 64'(p < 5 ? klens[p] : $urandom_range(0, 3)));
      for (int w = 0; w < 4; w++)
        write_reg(CFG_IDX_W'(w + 1), p == 0 ? '1 : (p == 1 ? '0 : rnd64()));
      run_blocks(N_RANDOM / 7);
      drain();
    end

    $display("covered %0d blocks (%0d encrypt, %0d decrypt) over all key length codes",
             n_blocks, n_enc, n_dec);
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("aes_block_encrypt_decrypt_top_tb passed");
    end else begin
      $display("aes_block_encrypt_decrypt_top_tb failed");
    end
    $finish;
  end

endmodule
